>>> src/mtsf_pkg.sv
package mtsf_pkg;

  localparam int TAPS_DEFAULT        = 64;
  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int COEFF_BITS_DEFAULT  = 16;

  // tap_count register and coefficient index field
  localparam int                  CFG_BITS      = 7;
  localparam logic [CFG_BITS-1:0] TAP_COUNT_RST = 7'd64;
  localparam int                  IDX_BITS      = 6;

  // tuser of an input word
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEFF  = 1'b1;

  // pipeline depth between the last tap read and a settled accumulator
  localparam int DRAIN_CYCLES = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic clear;    // preload accumulators with the rounding offset
    logic en;       // a tap product enters this cycle
    logic coef_ok;  // coefficient entry was written, else it reads as zero
  } mac_ctrl_t;

endpackage

>>> src/mtsf_ram.sv
module mtsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mtsf_cell.sv
module mtsf_cell #(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] val_q;

  // delay line starts out silent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

>>> src/mtsf_mac.sv
module mtsf_mac
  import mtsf_pkg::*;
#(
  parameter int SB       = SAMPLE_BITS_DEFAULT,
  parameter int CB       = COEFF_BITS_DEFAULT,
  parameter int ACC_BITS = SAMPLE_BITS_DEFAULT + COEFF_BITS_DEFAULT + 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_ctrl_t            ctrl_i,
  input  logic signed [SB-1:0] smp_i,
  input  logic signed [CB-1:0] coef_l_i,
  input  logic signed [CB-1:0] coef_r_i,
  output logic signed [SB-1:0] res_l_o,
  output logic signed [SB-1:0] res_r_o,
  output logic                 clip_o
);

  localparam int PW = SB + CB;
  localparam logic signed [ACC_BITS-1:0] RND  = ACC_BITS'(1) << (CB - 2);
  localparam logic signed [ACC_BITS-1:0] MAXV = (ACC_BITS'(1) << (SB - 1)) - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] MINV = ~MAXV;

  logic signed [CB-1:0]       cl_w, cr_w;
  logic signed [PW-1:0]       pl_d, pr_d, pl_q, pr_q;
  logic                       pv_q;
  logic signed [ACC_BITS-1:0] accl_q, accr_q;
  logic                       clip_l, clip_r;

  assign cl_w = ctrl_i.coef_ok ? coef_l_i : '0;
  assign cr_w = ctrl_i.coef_ok ? coef_r_i : '0;
  assign pl_d = smp_i * cl_w;
  assign pr_d = smp_i * cr_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d;
    pr_q <= pr_d;
    if (ctrl_i.clear) begin
      accl_q <= RND;
      accr_q <= RND;
    end else if (pv_q) begin
      accl_q <= accl_q + ACC_BITS'(pl_q);
      accr_q <= accr_q + ACC_BITS'(pr_q);
    end
  end

  // rounding offset is already in the sum: shift, then clamp
  function automatic logic [SB:0] finish(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] sh;
    logic [SB:0]                res;
    sh = acc >>> (CB - 1);
    if (sh > MAXV) begin
      res = {1'b1, MAXV[SB-1:0]};
    end else if (sh < MINV) begin
      res = {1'b1, MINV[SB-1:0]};
    end else begin
      res = {1'b0, sh[SB-1:0]};
    end
    return res;
  endfunction

  assign {clip_l, res_l_o} = finish(accl_q);
  assign {clip_r, res_r_o} = finish(accr_q);
  assign clip_o = clip_l | clip_r;

endmodule

>>> src/mono_to_stereo_fir_filter.sv
// channel     | dir | tdata (low bit up)                               | tuser
// s_axis      | in  | sample, coeff_index, coeff_left, coeff_right     | kind
// m_axis      | out | out_left, out_right                              | clipped
// cfg         | in  | cfg_wdata_i = tap_count, written when cfg_we_i   | -
//
// A sample word makes the delay ring of N cells, N = min(TAPS, 127), turn once past
// the single stereo multiply-accumulate, then passes the drain states and the finish
// state. A coefficient word is written into the store as it is taken.
// Reset clears the delay cells and the coefficient valid bits at once; tap_count is 64.
// The result waits in the output register while the next word is taken; the finish
// step holds only if that register is still full.
module mono_to_stereo_fir_filter
  import mtsf_pkg::*;
#(
  parameter int TAPS        = TAPS_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int COEFF_BITS  = COEFF_BITS_DEFAULT,
  localparam int IN_DW      = ((SAMPLE_BITS + IDX_BITS + 2 * COEFF_BITS + 7) / 8) * 8,
  localparam int OUT_DW     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // sample, coeff_index, coeff_left, coeff_right
  input  logic [IN_DW-1:0]    s_axis_tdata_i,
  // kind
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // out_left, out_right
  output logic [OUT_DW-1:0]   m_axis_tdata_o,
  // clipped
  output logic                m_axis_tuser_o,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i
);

  localparam int SB       = SAMPLE_BITS;
  localparam int CB       = COEFF_BITS;
  localparam int TC_MAX   = (1 << CFG_BITS) - 1;
  localparam int NCELL    = (TAPS < TC_MAX) ? TAPS : TC_MAX;
  localparam int CDEPTH   = (TAPS < (1 << IDX_BITS)) ? TAPS : (1 << IDX_BITS);
  localparam int CAW      = $clog2(CDEPTH);
  localparam int CW       = $clog2(NCELL);
  localparam int TW       = $clog2(NCELL + 1);
  localparam int ACC_BITS = SB + CB + $clog2(NCELL) + 1;

  localparam logic [CW-1:0] RUN_LAST   = CW'(NCELL - 1);
  localparam logic [CW-1:0] DRAIN_LAST = CW'(DRAIN_CYCLES - 1);

  // input word fields
  logic [SB-1:0]       in_smp;
  logic [IDX_BITS-1:0] in_idx;
  logic [CB-1:0]       in_cl, in_cr;

  assign in_smp = s_axis_tdata_i[SB-1:0];
  assign in_idx = s_axis_tdata_i[SB+IDX_BITS-1:SB];
  assign in_cl  = s_axis_tdata_i[SB+IDX_BITS+CB-1:SB+IDX_BITS];
  assign in_cr  = s_axis_tdata_i[SB+IDX_BITS+2*CB-1:SB+IDX_BITS+CB];

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CFG_BITS-1:0] tc_q;
  logic              s_acc, smp_acc, coef_we;
  logic              in_rdy, shift_en, rotate, clear, load_out, slot_free;

  assign s_acc   = s_axis_tvalid_i && in_rdy;
  assign smp_acc = s_acc && (s_axis_tuser_i == KIND_SAMPLE);
  assign coef_we = s_acc && (s_axis_tuser_i == KIND_COEFF) && (int'(in_idx) < CDEPTH);
  assign slot_free = !m_axis_tvalid_o || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= TAP_COUNT_RST;
    end else if (cfg_we_i) begin
      tc_q <= cfg_wdata_i;
    end
  end

  // effective tap count, 0 acts as 1, clamp at the ring length
  logic [TW-1:0] t_use, start_w, k_w;
  logic          in_win, k_ok;

  always_comb begin
    if (tc_q == '0) begin
      t_use = TW'(1);
    end else if (int'(tc_q) > NCELL) begin
      t_use = TW'(NCELL);
    end else begin
      t_use = TW'(tc_q);
    end
  end

  // ring head shows d[N-1-cnt]; taps are used once cnt reaches N - t
  assign start_w = TW'(NCELL) - t_use;
  assign in_win  = (state_q == ST_RUN) && (TW'(cnt_q) >= start_w);
  assign k_w     = TW'(cnt_q) - start_w;
  assign k_ok    = int'(k_w) < CDEPTH;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        if (cnt_q == RUN_LAST) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (cnt_q == DRAIN_LAST) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy   = 1'b0;
    shift_en = 1'b0;
    rotate   = 1'b0;
    clear    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_rdy   = 1'b1;
        shift_en = s_axis_tvalid_i && (s_axis_tuser_i == KIND_SAMPLE);
        clear    = s_axis_tvalid_i && (s_axis_tuser_i == KIND_SAMPLE);
      end
      ST_RUN: begin
        shift_en = 1'b1;
        rotate   = 1'b1;
      end
      ST_DRAIN: ;
      ST_FIN: load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign s_axis_tready_o = in_rdy;

  // delay ring: shifts in a new sample, then turns once during the sum
  logic [SB-1:0] cell_q [NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [SB-1:0] cell_d;
    if (i == 0) begin : g_head
      assign cell_d = rotate ? cell_q[NCELL-1] : in_smp;
    end else begin : g_body
      assign cell_d = cell_q[i-1];
    end
    mtsf_cell #(
      .W (SB)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (shift_en),
      .d_i    (cell_d),
      .q_o    (cell_q[i])
    );
  end

  // coefficient store, entries read as zero until written
  logic [CDEPTH-1:0] cvld_q;
  logic [2*CB-1:0]   coef_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q <= '0;
    end else if (coef_we) begin
      cvld_q[in_idx[CAW-1:0]] <= 1'b1;
    end
  end

  mtsf_ram #(
    .WIDTH (2 * CB),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (in_idx[CAW-1:0]),
    .wdata_i ({in_cr, in_cl}),
    .raddr_i (k_w[CAW-1:0]),
    .rdata_o (coef_rd)
  );

  // stage lined up with the registered coefficient read
  logic          v1_q, ok1_q;
  logic [SB-1:0] smp1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      ok1_q <= 1'b0;
    end else begin
      v1_q  <= in_win;
      ok1_q <= in_win && k_ok && cvld_q[k_w[CAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    smp1_q <= cell_q[NCELL-1];
  end

  mac_ctrl_t     mac_ctrl;
  logic [SB-1:0] res_l, res_r;
  logic          res_clip;

  assign mac_ctrl.clear   = clear;
  assign mac_ctrl.en      = v1_q;
  assign mac_ctrl.coef_ok = ok1_q;

  mtsf_mac #(
    .SB       (SB),
    .CB       (CB),
    .ACC_BITS (ACC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .smp_i    (smp1_q),
    .coef_l_i (coef_rd[CB-1:0]),
    .coef_r_i (coef_rd[2*CB-1:CB]),
    .res_l_o  (res_l),
    .res_r_o  (res_r),
    .clip_o   (res_clip)
  );

  // output word register
  logic          ovld_q, ovld_d;
  logic [SB-1:0] outl_q, outr_q;
  logic          clip_q;

  always_comb begin
    ovld_d = ovld_q;
    if (load_out) begin
      ovld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      outl_q <= res_l;
      outr_q <= res_r;
      clip_q <= res_clip;
    end
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = OUT_DW'({outr_q, outl_q});
  assign m_axis_tuser_o  = clip_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mtsf_pkg::*;

  localparam int TAPS          = TAPS_DEFAULT;
  localparam int SBITS         = SAMPLE_BITS_DEFAULT;
  localparam int CBITS         = COEFF_BITS_DEFAULT;
  localparam int IN_DW         = ((SBITS + IDX_BITS + 2 * CBITS + 7) / 8) * 8;
  localparam int OUT_DW        = ((2 * SBITS + 7) / 8) * 8;
  localparam int IN_PAD        = IN_DW - SBITS - IDX_BITS - 2 * CBITS;
  localparam int SETTLE_CYCLES = TAPS + 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 40;

  typedef struct {
    logic                    kind;
    logic signed [SBITS-1:0] sample;
    logic [IDX_BITS-1:0]     idx;
    logic signed [CBITS-1:0] coef_l;
    logic signed [CBITS-1:0] coef_r;
  } in_word_t;

  typedef struct {
    logic signed [SBITS-1:0] left;
    logic signed [SBITS-1:0] right;
    logic                    clip;
  } stereo_pair_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [IN_DW-1:0]    s_axis_tdata_i  = '0;  // sample, coeff_index, coeff_left, coeff_right
  logic                s_axis_tuser_i  = KIND_SAMPLE;  // kind
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OUT_DW-1:0]   m_axis_tdata_o;  // out_left, out_right
  logic                m_axis_tuser_o;  // clipped
  logic                cfg_we_i        = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata_i     = '0;

  // filter state mirrored on the testbench side
  logic signed [SBITS-1:0] sample_hist [TAPS];
  logic signed [CBITS-1:0] left_coef   [TAPS];
  logic signed [CBITS-1:0] right_coef  [TAPS];
  logic [CFG_BITS-1:0]     tap_cfg = TAP_COUNT_RST;

  in_word_t     pending_words [$];
  stereo_pair_t expected_pairs [$];
  in_word_t     word_on_bus;
  stereo_pair_t head;

  int  err_count     = 0;
  int  sample_words  = 0;
  int  coeff_words   = 0;
  int  pairs_checked = 0;
  int  clip_count    = 0;
  int  tap_settings  = 0;
  int  cycle_count   = 0;
  int  send_pct      = 0;
  int  recv_pct      = 0;
  bit  hold_armed    = 1'b0;
  logic hold_off     = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  mono_to_stereo_fir_filter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // round half up to Q1.15, saturate; top bit flags clipping
  function automatic logic [SBITS:0] round_sat(input longint acc);
    longint           v;
    longint           hi;
    logic             sat;
    logic [SBITS-1:0] res;
    hi  = (longint'(1) <<< (SBITS - 1)) - 1;
    v   = (acc + (longint'(1) <<< (CBITS - 2))) >>> (CBITS - 1);
    sat = 1'b0;
    if (v > hi) begin
      sat = 1'b1;
      v   = hi;
    end else if (v < -hi - 1) begin
      sat = 1'b1;
      v   = -hi - 1;
    end
    res = v[SBITS-1:0];
    return {sat, res};
  endfunction

  task automatic apply_word(input in_word_t w);
    longint         acc_l;
    longint         acc_r;
    int             n;
    int             j;
    int             k;
    logic [SBITS:0] lres;
    logic [SBITS:0] rres;
    stereo_pair_t   p;
    if (w.kind == KIND_COEFF) begin
      if (w.idx < TAPS) begin
        left_coef[w.idx]  = w.coef_l;
        right_coef[w.idx] = w.coef_r;
      end
      coeff_words++;
    end else begin
      for (j = TAPS - 1; j > 0; j--) sample_hist[j] = sample_hist[j - 1];
      sample_hist[0] = w.sample;
      if (tap_cfg == 0) n = 1;
      else if (tap_cfg > TAPS) n = TAPS;
      else n = int'(tap_cfg);
      acc_l = 0;
      acc_r = 0;
      // oldest sample in the window meets tap 0
      for (k = 0; k < n; k++) begin
        acc_l += longint'(left_coef[k]) * longint'(sample_hist[n - 1 - k]);
        acc_r += longint'(right_coef[k]) * longint'(sample_hist[n - 1 - k]);
      end
      lres    = round_sat(acc_l);
      rres    = round_sat(acc_r);
      p.left  = lres[SBITS-1:0];
      p.right = rres[SBITS-1:0];
      p.clip  = lres[SBITS] | rres[SBITS];
      if (p.clip) clip_count++;
      expected_pairs.push_back(p);
      sample_words++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [SBITS-1:0] got,
                                 input logic [SBITS-1:0] want);
    if (err_count < MAX_REPORTS)
      $display("[%0t] pair %0d %s: got %h want %h", $time, pairs_checked, what, got, want);
    err_count++;
  endtask

  // sender: holds a word until taken, gaps at send_pct percent
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) apply_word(word_on_bus);
      if (pending_words.size() > 0 && $urandom_range(99) >= send_pct) begin
        word_on_bus     = pending_words.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= word_on_bus.kind;
        s_axis_tdata_i  <= {{IN_PAD{1'b0}}, word_on_bus.coef_r, word_on_bus.coef_l,
                            word_on_bus.idx, word_on_bus.sample};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: checks each word taken, stalls at recv_pct percent
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("stray word", m_axis_tdata_o[SBITS-1:0], '0);
        end else begin
          head = expected_pairs.pop_front();
          if (m_axis_tdata_o[SBITS-1:0] !== head.left)
            report_mismatch("out_left", m_axis_tdata_o[SBITS-1:0], head.left);
          if (m_axis_tdata_o[2*SBITS-1:SBITS] !== head.right)
            report_mismatch("out_right", m_axis_tdata_o[2*SBITS-1:SBITS], head.right);
          if (m_axis_tuser_o !== head.clip)
            report_mismatch("clipped", SBITS'(m_axis_tuser_o), SBITS'(head.clip));
        end
        pairs_checked++;
      end
      if (hold_off) m_axis_tready_i <= 1'b0;
      else m_axis_tready_i <= ($urandom_range(99) >= recv_pct);
    end
  end

  // one long output stall so the filter backs up into its input
  initial begin : long_hold
    wait (hold_armed);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d pairs outstanding", cycle_count,
               expected_pairs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [SBITS-1:0] rand_q15();
    logic [SBITS-1:0] raw;
    int               pick;
    pick = $urandom_range(9);
    raw  = SBITS'($urandom);
    if (pick == 0) return {1'b0, {(SBITS - 1){1'b1}}};
    if (pick == 1) return {1'b1, {(SBITS - 1){1'b0}}};
    if (pick == 2) return '0;
    // mostly scaled down so long filters do not clip every time
    return $signed(raw) >>> $urandom_range(0, 5);
  endfunction

  task automatic push_sample(input logic signed [SBITS-1:0] value);
    in_word_t w;
    w.kind   = KIND_SAMPLE;
    w.sample = value;
    w.idx    = IDX_BITS'($urandom);
    w.coef_l = CBITS'($urandom);
    w.coef_r = CBITS'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic push_coeff(input int tap, input logic signed [CBITS-1:0] cl,
                            input logic signed [CBITS-1:0] cr);
    in_word_t w;
    w.kind   = KIND_COEFF;
    w.sample = SBITS'($urandom);
    w.idx    = IDX_BITS'(tap);
    w.coef_l = cl;
    w.coef_r = cr;
    pending_words.push_back(w);
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || s_axis_tvalid_i || expected_pairs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_taps(input logic [CFG_BITS-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tap_cfg      = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tap_settings++;
  endtask

  // load the taps in use, then a random mix of samples and coefficient updates
  task automatic random_phase(input int taps_in_use, input int count);
    int i;
    for (i = 0; i < taps_in_use; i++) push_coeff(i, rand_q15(), rand_q15());
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 12) push_coeff($urandom_range(TAPS - 1), rand_q15(), rand_q15());
      else push_sample(rand_q15());
    end
  endtask

  initial begin : stimulus
    int i;
    int n;
    for (i = 0; i < TAPS; i++) begin
      sample_hist[i] = '0;
      left_coef[i]   = '0;
      right_coef[i]  = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stores give silence; then full-scale taps at both ends
    push_sample(16'sh7fff);
    push_coeff(0, 16'sh7fff, 16'sh8000);
    push_coeff(TAPS - 1, 16'sh8000, 16'sh7fff);
    push_coeff(1, 16'sh4000, 16'shc000);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_sample(16'sh0001);
    push_sample(16'shffff);
    // single tap: -1 * -1 clips high
    set_taps(1);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    // zero count behaves as one tap
    set_taps(0);
    push_sample(16'sh1234);
    push_coeff(1, 16'sh8000, 16'sh8000);
    // two taps of -1 against +1 clip low
    set_taps(2);
    push_sample(16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    // count above the store size behaves as the full length
    set_taps(127);
    push_sample(16'sh0000);
    push_sample(16'sh4000);

    set_taps(4);
    random_phase(4, 100);

    set_taps(64);
    send_pct = 60;
    random_phase(64, 120);

    set_taps(1);
    send_pct = 0;
    recv_pct = 60;
    random_phase(1, 80);

    n = $urandom_range(2, TAPS - 1);
    set_taps(CFG_BITS'(n));
    send_pct = 14;
    recv_pct = 14;
    random_phase(n, 100);

    set_taps(8);
    send_pct   = 0;
    recv_pct   = 0;
    hold_armed = 1'b1;
    random_phase(8, 80);

    set_taps(64);
    send_pct = 14;
    recv_pct = 14;
    random_phase(64, 100);

    settle();
    $display("Checked %0d stereo pairs (%0d clipped) from %0d samples and %0d tap writes",
             pairs_checked, clip_count, sample_words, coeff_words);
    $display("Tap count set %0d times from 0 to 127, with input gaps, output stalls and a hold",
             tap_settings);
    if (err_count == 0 && expected_pairs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
